FILE: rtl/core/hls_pkg.sv
package hls_pkg;

	// Number of hyperplanes (signature bits) and vector length
	localparam int HASH_BITS = 10;
	localparam int DIM = 64;

	// Fixed field widths
	localparam int PLANE_W = 4;
	localparam int ELEM_W = 6;
	localparam int SMP_W = 16;

	// Derived widths
	localparam int ADDR_W = (DIM > 1) ? $clog2(DIM) : 1;
	localparam int CNT_W = $clog2(DIM + 1);
	localparam int PROD_W = 2 * SMP_W;
	localparam int ACC_W = PROD_W + CNT_W - 1;

	// Stream widths
	localparam int S_DATA_W = 32;
	localparam int M_DATA_W = ((HASH_BITS + 1 + 7) / 8) * 8;

	// Transaction kinds on s_tuser
	localparam logic ACT_COEF = 1'b0;
	localparam logic ACT_ELEM = 1'b1;

	// Per-stage element info produced by the sequencer
	typedef struct packed {
		logic elem;
		logic acc_en;
		logic last;
		logic ovr;
	} seq_info_t;

	// Shared control for all plane lanes
	typedef struct packed {
		logic adv;
		logic [ADDR_W-1:0] waddr;
		logic [ADDR_W-1:0] raddr;
		logic acc_en_s2;
		logic clr_s2;
		logic upd_s2;
	} lane_ctl_t;

endpackage

FILE: rtl/core/hyperplane_lsh_signature.sv
// Pipeline: the last element passes through the coefficient RAM read with element capture,
//   the multiply, then the accumulate/sign into the output register before m_tvalid rises.
// Throughput: one transaction per cycle while s_tready is high, coefficient writes and
//   elements alike; every plane has its own coefficient RAM read and multiplier each cycle.
// Reset: arst_n clears accumulators, element counter, overrun flag and valids;
//   the coefficient RAMs hold garbage until written.
module hyperplane_lsh_signature
	import hls_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// [3:0] plane_index, [9:4] elem_index, [25:10] sample_value, rest zero
	input  logic [S_DATA_W-1:0] s_tdata,
	// [0] action
	input  logic                s_tuser,
	input  logic                s_tlast,
	output logic                m_tvalid,
	input  logic                m_tready,
	// [HASH_BITS-1:0] signature, [HASH_BITS] overrun, rest zero
	output logic [M_DATA_W-1:0] m_tdata
);

	logic [PLANE_W-1:0]      plane_index;
	logic [ELEM_W-1:0]       elem_index;
	logic signed [SMP_W-1:0] sample;
	logic                    accept;
	logic                    stall;
	logic                    wr_ok;
	logic [ADDR_W-1:0]       raddr;
	seq_info_t               info;
	lane_ctl_t               ctl;

	logic                    v_s1, v_s2;
	seq_info_t               info_s1, info_s2;
	logic signed [SMP_W-1:0] elem_s1;

	logic [HASH_BITS-1:0]    pos;
	logic [HASH_BITS-1:0]    sig;
	logic [HASH_BITS-1:0]    sig_q;
	logic                    ovr_q;
	logic                    m_valid_q;

	assign plane_index = s_tdata[PLANE_W-1:0];
	assign elem_index  = s_tdata[PLANE_W+ELEM_W-1:PLANE_W];
	assign sample      = s_tdata[PLANE_W+ELEM_W+SMP_W-1:PLANE_W+ELEM_W];

	// Hold everything only when a result must enter a full output register
	assign stall    = m_valid_q && !m_tready && v_s2 && info_s2.last;
	assign s_tready = !stall;
	assign accept   = s_tvalid && s_tready;

	assign wr_ok = accept && (s_tuser == ACT_COEF) && (32'(elem_index) < DIM);

	hls_seq u_seq (
		.clk   (clk),
		.arst_n(arst_n),
		.accept(accept),
		.action(s_tuser),
		.last  (s_tlast),
		.raddr (raddr),
		.info  (info)
	);

	// Element pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (!stall) begin
			v_s1 <= info.elem;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			info_s1 <= info;
			info_s2 <= info_s1;
			elem_s1 <= sample;
		end
	end

	assign ctl.adv       = !stall;
	assign ctl.waddr     = ADDR_W'(elem_index);
	assign ctl.raddr     = raddr;
	assign ctl.acc_en_s2 = info_s2.acc_en;
	assign ctl.clr_s2    = info_s2.last;
	assign ctl.upd_s2    = v_s2 && !stall;

	// One lane per hyperplane, plane 0 at the signature MSB
	for (genvar p = 0; p < HASH_BITS; p++) begin : g_lane
		hls_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.we     (wr_ok && (32'(plane_index) == p)),
			.wdata  (sample),
			.elem_s1(elem_s1),
			.pos    (pos[p])
		);
		assign sig[HASH_BITS-1-p] = pos[p];
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (!stall && v_s2 && info_s2.last) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall && v_s2 && info_s2.last) begin
			sig_q <= sig;
			ovr_q <= info_s2.ovr;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = M_DATA_W'({ovr_q, sig_q});

	// A new result only comes from a last element in the accumulate stage
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(v_s2 && info_s2.last))
		else $error("result without a last element in the accumulate stage");

	// The input side only backs off while a result waits on a full output
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready && v_s2))
		else $error("input stalled without a pending result");

endmodule

FILE: rtl/core/hls_ram.sv
module hls_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port with enable
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/core/hls_seq.sv
module hls_seq
	import hls_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic              action,
	input  logic              last,
	output logic [ADDR_W-1:0] raddr,
	output seq_info_t         info
);

	logic [CNT_W-1:0] cnt_q;
	logic             ovr_q;
	logic             is_elem;
	logic             in_range;

	assign is_elem  = accept && (action == ACT_ELEM);
	assign in_range = cnt_q < CNT_W'(DIM);
	assign raddr    = cnt_q[ADDR_W-1:0];

	// What this element does downstream
	assign info.elem   = is_elem;
	assign info.acc_en = is_elem && in_range;
	assign info.last   = is_elem && last;
	assign info.ovr    = ovr_q || !in_range;

	// Element counter saturates at DIM; extra elements flag overrun
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovr_q <= 1'b0;
		end else if (is_elem) begin
			if (last) begin
				cnt_q <= '0;
				ovr_q <= 1'b0;
			end else if (in_range) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				ovr_q <= 1'b1;
			end
		end
	end

endmodule

FILE: rtl/core/hls_lane.sv
module hls_lane
	import hls_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  lane_ctl_t               ctl,
	input  logic                    we,
	input  logic signed [SMP_W-1:0] wdata,
	input  logic signed [SMP_W-1:0] elem_s1,
	output logic                    pos
);

	logic signed [SMP_W-1:0]  coef_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  sum;

	// Coefficients of this plane, one per element position
	hls_ram #(
		.WIDTH(SMP_W),
		.DEPTH(DIM)
	) u_coef (
		.clk  (clk),
		.we   (we),
		.waddr(ctl.waddr),
		.wdata(wdata),
		.re   (ctl.adv),
		.raddr(ctl.raddr),
		.rdata(coef_s1)
	);

	// Product stage
	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			prod_s2 <= coef_s1 * elem_s1;
		end
	end

	// Accumulate; the sign of the updated sum gives this plane's bit
	assign sum = acc_q + (ctl.acc_en_s2 ? ACC_W'(prod_s2) : ACC_W'(0));
	assign pos = !sum[ACC_W-1] && (sum != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.upd_s2) begin
			acc_q <= ctl.clr_s2 ? '0 : sum;
		end
	end

endmodule

FILE: verif/hls_signature_checker.sv
module hls_signature_checker
	import hls_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                s_tready,
	// [3:0] plane_index, [9:4] elem_index, [25:10] sample_value, rest zero
	input  logic [S_DATA_W-1:0] s_tdata,
	// [0] action
	input  logic                s_tuser,
	input  logic                s_tlast,
	input  logic                m_tvalid,
	input  logic                m_tready,
	// [HASH_BITS-1:0] signature, [HASH_BITS] overrun, rest zero
	input  logic [M_DATA_W-1:0] m_tdata,
	output int                  errors,
	output int                  pending
);

	typedef struct packed {
		logic [HASH_BITS-1:0] signature;
		logic                 overrun;
	} hash_result_t;

	// Shadow copy of the block state
	logic signed [SMP_W-1:0] coef_mem [HASH_BITS*DIM];
	logic signed [ACC_W-1:0] dot_acc [HASH_BITS];
	int unsigned             elem_count;
	logic                    ovr_seen;
	hash_result_t            expected_signatures [$];
	int                      mismatch_count;

	// Update the shadow state with one input transaction; queue a signature on last
	task automatic predict_signature();
		logic [PLANE_W-1:0]      plane;
		logic [ELEM_W-1:0]       elem;
		logic signed [SMP_W-1:0] value;
		hash_result_t            res;
		plane = s_tdata[PLANE_W-1:0];
		elem = s_tdata[PLANE_W +: ELEM_W];
		value = s_tdata[PLANE_W+ELEM_W +: SMP_W];
		if (s_tuser == ACT_COEF) begin
			// out-of-range writes and the last flag are ignored
			if (plane < HASH_BITS && elem < DIM)
				coef_mem[plane*DIM + elem] = value;
		end else begin
			if (elem_count < DIM) begin
				for (int p = 0; p < HASH_BITS; p++)
					dot_acc[p] = dot_acc[p] + coef_mem[p*DIM + elem_count] * value;
				elem_count++;
			end else begin
				ovr_seen = 1'b1;
			end
			if (s_tlast) begin
				// plane 0 lands in the MSB; strictly positive sets the bit
				for (int p = 0; p < HASH_BITS; p++)
					res.signature[HASH_BITS-1-p] = (dot_acc[p] > 0);
				res.overrun = ovr_seen;
				expected_signatures.insert(expected_signatures.size(), res);
				for (int p = 0; p < HASH_BITS; p++)
					dot_acc[p] = '0;
				elem_count = 0;
				ovr_seen = 1'b0;
			end
		end
	endtask

	// Compare one output transaction with the oldest expected signature
	task automatic compare_signature();
		hash_result_t exp_res;
		if (expected_signatures.size() == 0) begin
			$error("unexpected output transaction, m_tdata=%h", m_tdata);
			mismatch_count++;
		end else begin
			exp_res = expected_signatures.pop_front();
			if (m_tdata[HASH_BITS-1:0] !== exp_res.signature) begin
				$error("signature: expected %h, actual %h",
					exp_res.signature, m_tdata[HASH_BITS-1:0]);
				mismatch_count++;
			end
			if (m_tdata[HASH_BITS] !== exp_res.overrun) begin
				$error("overrun: expected %b, actual %b", exp_res.overrun, m_tdata[HASH_BITS]);
				mismatch_count++;
			end
			if (m_tdata[M_DATA_W-1:HASH_BITS+1] !== '0) begin
				$error("padding: expected 0, actual %h", m_tdata[M_DATA_W-1:HASH_BITS+1]);
				mismatch_count++;
			end
		end
	endtask

	// Watch both channels at every rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < HASH_BITS; p++)
				dot_acc[p] = '0;
			elem_count = 0;
			ovr_seen = 1'b0;
			mismatch_count = 0;
			expected_signatures.delete();
			errors <= 0;
			pending <= 0;
		end else begin
			if (m_tvalid && m_tready)
				compare_signature();
			if (s_tvalid && s_tready)
				predict_signature();
			errors <= mismatch_count;
			pending <= expected_signatures.size();
		end
	end

endmodule

FILE: verif/tb_hyperplane_lsh_signature.sv
module tb_hyperplane_lsh_signature;
	import hls_pkg::*;

	localparam int RANDOM_ITEMS_END = 1900;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic                s_tuser = ACT_COEF;
	logic                s_tlast = 1'b0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;
	int                  errors;
	int                  pending;

	// Idle control; the calm flag is shared by both sides
	logic calm = 1'b0;
	logic stall_req = 1'b0;
	int   stall_left = 0;
	int   items_sent = 0;

	always #6 clk = ~clk;

	hyperplane_lsh_signature dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	hls_signature_checker chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.errors   (errors),
		.pending  (pending)
	);

	// Receiver: random backpressure, plus a long hold-off on request
	always @(posedge clk) begin
		if (stall_req)
			stall_left <= 400;
		else if (stall_left != 0)
			stall_left <= stall_left - 1;
		m_tready <= !(stall_req || stall_left > 1) && (calm || $urandom_range(99) >= 16);
	end

	// Sample values biased toward the extremes
	function automatic logic [SMP_W-1:0] pick_sample();
		case ($urandom_range(15))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'hffff;
			default: return SMP_W'($urandom);
		endcase
	endfunction

	// Offer one transaction and hold it until accepted
	task automatic send_item(input logic act, input logic [PLANE_W-1:0] plane,
		input logic [ELEM_W-1:0] elem, input logic [SMP_W-1:0] value, input logic last);
		while (!calm && $urandom_range(99) < 16) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tlast <= last;
		s_tdata <= S_DATA_W'({value, elem, plane});
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic write_coef(input logic [PLANE_W-1:0] plane, input logic [ELEM_W-1:0] elem,
		input logic [SMP_W-1:0] value, input logic last);
		send_item(ACT_COEF, plane, elem, value, last);
	endtask

	// Index fields are don't-care for elements, so fill them with noise
	task automatic send_element(input logic [SMP_W-1:0] value, input logic last);
		send_item(ACT_ELEM, PLANE_W'($urandom), ELEM_W'($urandom), value, last);
	endtask

	// Stray coefficient write; planes above HASH_BITS-1 get dropped by the block
	task automatic noise_write();
		write_coef(PLANE_W'($urandom), ELEM_W'($urandom), pick_sample(), 1'($urandom));
	endtask

	// One vector of random content, with occasional coefficient writes mixed in
	task automatic send_vector(input int len);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(99) < 4)
				noise_write();
			send_element(pick_sample(), i == len - 1);
		end
	endtask

	// Stop offering and wait for every expected signature
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin
		int k;
		int len;
		int wait_cycles;
		logic paused;
		paused = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill the whole coefficient store before any element is read
		for (int p = 0; p < HASH_BITS; p++)
			for (int e = 0; e < DIM; e++)
				write_coef(PLANE_W'(p), ELEM_W'(e),
					(p == 0) ? 16'h8000 : (p == 1) ? 16'h7fff : pick_sample(), 1'b0);

		// Directed: zero dot product, extreme elements
		send_element(16'h0000, 1'b1);
		send_element(16'h8000, 1'b1);
		send_element(16'h7fff, 1'b1);
		// Last flag on a write, out-of-range planes, top corner of the store
		write_coef(4'd3, 6'd0, 16'h7fff, 1'b1);
		write_coef(4'd15, 6'd63, 16'h7fff, 1'b1);
		write_coef(4'd10, 6'd0, 16'h8000, 1'b0);
		write_coef(4'd9, 6'd63, 16'h8000, 1'b0);
		send_item(ACT_ELEM, 4'hf, 6'h3f, 16'hffff, 1'b0);
		send_item(ACT_ELEM, 4'h0, 6'h00, 16'h0001, 1'b1);
		// Full-length vector of largest products, then overruns
		for (int i = 0; i < DIM; i++)
			send_element(16'h8000, i == DIM - 1);
		for (int i = 0; i <= DIM; i++)
			send_element(16'h8000, i == DIM);
		send_vector(DIM + 3);
		drain();

		// Receiver holds off while short vectors keep coming
		stall_req <= 1'b1;
		@(posedge clk);
		stall_req <= 1'b0;
		for (int i = 0; i < 40; i++)
			send_element(pick_sample(), 1'b1);

		// Random part: mostly well-formed vectors, some stray writes
		while (items_sent < RANDOM_ITEMS_END) begin
			calm <= (items_sent >= 1000 && items_sent < 1300);
			if (!paused && items_sent >= 1500) begin
				paused = 1'b1;
				drain();
			end
			k = $urandom_range(99);
			if (k < 8) begin
				noise_write();
			end else begin
				k = $urandom_range(99);
				if (k < 65)
					len = $urandom_range(8, 1);
				else if (k < 88)
					len = $urandom_range(DIM - 1, 9);
				else if (k < 94)
					len = DIM;
				else
					len = $urandom_range(DIM + 8, DIM + 1);
				send_vector(len);
			end
		end
		s_tvalid <= 1'b0;

		// Wait out the remaining signatures, with a cap
		wait_cycles = 0;
		@(posedge clk);
		while (pending != 0 && wait_cycles < 5000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (8) @(posedge clk);
		if (pending != 0)
			$error("%0d expected signatures never arrived", pending);
		if (errors == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Hard stop
	initial begin
		#3000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/hls_pkg.sv
rtl/core/hls_ram.sv
rtl/core/hls_seq.sv
rtl/core/hls_lane.sv
rtl/core/hyperplane_lsh_signature.sv
verif/hls_signature_checker.sv
verif/tb_hyperplane_lsh_signature.sv
